>>> design/gpfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse feature extractor package
// Widths, limits and register indexes shared by the extractor.
// ----------------------------------------------------------------------------
package gpfe_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int IDX_W        = 13;
	localparam int SUM_W        = 27;
	localparam int OFF_W        = 11;
	localparam int GATE_START_W = 12;
	localparam int GATE_LEN_W   = 11;
	localparam int PERIOD_W     = 16;
	localparam int CHARGE_W     = 32;
	localparam int TIME_W       = 28;
	localparam int PROD_W       = SUM_W + PERIOD_W + 1;
	localparam int SCALED_W     = PROD_W - 8;
	localparam int TPROD_W      = OFF_W + PERIOD_W;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int OUT_DATA_W   = 136;
	localparam int OUT_BITS     = CHARGE_W + SAMPLE_W + 3 * TIME_W;

	localparam logic [GATE_LEN_W-1:0] MAX_GATE   = GATE_LEN_W'(1024);
	localparam logic [IDX_W-1:0]      IDX_MAX    = {IDX_W{1'b1}};
	localparam logic [PERIOD_W-1:0]   PERIOD_RST = PERIOD_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_START    = 2'd0,
		REG_GATE_LENGTH   = 2'd1,
		REG_THRESHOLD     = 2'd2,
		REG_SAMPLE_PERIOD = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> design/gated_pulse_feature_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gated pulse feature extractor
// Integral, peak, time over threshold, arrival and peak time of a gated pulse.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream, one item per cycle while s_tready is high,
//   s_tlast on the final sample of a waveform. Samples whose index lies in the
//   gate [gate_start, gate_start + min(gate_length, 1024)) are summed, searched
//   for the first maximum and compared with the threshold. The last sample
//   produces one result item on the m_ stream; other samples produce none.
//   Throughput: one sample per cycle while s_tready is high, set by the
//   single accumulate stage. The result passes the snapshot, multiply and
//   result registers; scale and saturate feed the result register.
//   The cfg_ channel writes registers by index; cfg_ready is always high.
//   Write registers only while no waveform is in flight.
//   Reset clears the accumulators and empties the result pipeline; registers
//   return to gate_start 0, gate_length 0, threshold 0, period 256.
//   When m_tready is low the result pipeline holds; s_tready drops only once
//   all three result stages are full and a further item could need one.
// ----------------------------------------------------------------------------
module gated_pulse_feature_extractor
	import gpfe_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
	input  wire logic                    s_tlast,   // last_sample
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [OUT_DATA_W-1:0]        m_tdata,   // charge[31:0], peak_value[47:32],
	                                                // time_over[75:48],
	                                                // arrival_time[103:76],
	                                                // peak_time[131:104], zero pad
	output logic                         m_tuser,   // fired
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam logic signed [TIME_W-1:0] NO_TIME = {{(TIME_W-8){1'b1}}, 8'h00};

	logic [GATE_START_W-1:0]     gate_start_q;
	logic [GATE_LEN_W-1:0]       gate_len_q;
	logic signed [SAMPLE_W-1:0]  thresh_q;
	logic [PERIOD_W-1:0]         period_q;

	logic [IDX_W-1:0]            idx_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [SAMPLE_W-1:0]  max_q;
	logic [OFF_W-1:0]            max_off_q;
	logic [OFF_W-1:0]            first_off_q;
	logic                        seen_q;
	logic [OFF_W-1:0]            cnt_q;
	logic                        has_q;

	logic [GATE_LEN_W-1:0]       len_clip;
	logic [IDX_W-1:0]            idx_rel;
	logic                        in_gate;
	logic [OFF_W-1:0]            off;
	logic signed [SAMPLE_W-1:0]  samp;
	logic                        take_max;
	logic                        above;
	logic signed [SUM_W-1:0]     sum_n;
	logic signed [SAMPLE_W-1:0]  max_n;
	logic [OFF_W-1:0]            max_off_n;
	logic [OFF_W-1:0]            first_off_n;
	logic                        seen_n;
	logic [OFF_W-1:0]            cnt_n;
	logic                        has_n;
	logic                        fired_n;

	logic                        acc;
	logic                        adv1;
	logic                        adv2;

	logic                        v_s1;
	logic                        fired_s1;
	logic                        seen_s1;
	logic signed [SUM_W-1:0]     sum_s1;
	logic signed [SAMPLE_W-1:0]  max_s1;
	logic [OFF_W-1:0]            max_off_s1;
	logic [OFF_W-1:0]            first_off_s1;
	logic [OFF_W-1:0]            cnt_s1;

	logic                        v_s2;
	logic                        fired_s2;
	logic                        seen_s2;
	logic signed [SAMPLE_W-1:0]  max_s2;
	logic signed [PROD_W-1:0]    prod_s2;
	logic [TPROD_W-1:0]          tover_s2;
	logic [TPROD_W-1:0]          arr_s2;
	logic [TPROD_W-1:0]          ptime_s2;

	logic [PROD_W-1:0]           prod_bias;
	logic signed [SCALED_W-1:0]  scaled;
	logic signed [CHARGE_W-1:0]  charge_sat;
	logic signed [CHARGE_W-1:0]  charge_n;
	logic signed [SAMPLE_W-1:0]  peak_n;
	logic signed [TIME_W-1:0]    tover_n;
	logic signed [TIME_W-1:0]    arr_n;
	logic signed [TIME_W-1:0]    ptime_n;

	logic                        out_v_q;
	logic                        fired_q;
	logic [OUT_BITS-1:0]         out_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_start_q <= '0;
			gate_len_q   <= '0;
			thresh_q     <= '0;
			period_q     <= PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GATE_START:    gate_start_q <= cfg_data[GATE_START_W-1:0];
				REG_GATE_LENGTH:   gate_len_q   <= cfg_data[GATE_LEN_W-1:0];
				REG_THRESHOLD:     thresh_q     <= signed'(cfg_data[SAMPLE_W-1:0]);
				REG_SAMPLE_PERIOD: period_q     <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv2     = !out_v_q || m_tready;
	assign adv1     = !v_s2 || adv2;
	assign s_tready = !v_s1 || adv1;
	assign acc      = s_tvalid && s_tready;

	// gate and accumulate
	always_comb begin
		len_clip    = (gate_len_q > MAX_GATE) ? MAX_GATE : gate_len_q;
		idx_rel     = idx_q - {1'b0, gate_start_q};
		in_gate     = (idx_q >= {1'b0, gate_start_q}) &&
		              (idx_rel < {{(IDX_W-GATE_LEN_W){1'b0}}, len_clip});
		off         = idx_rel[OFF_W-1:0];
		samp        = signed'(s_tdata);
		take_max    = in_gate && (!has_q || samp > max_q);
		above       = in_gate && (samp > thresh_q);
		sum_n       = in_gate ? sum_q + {{(SUM_W-SAMPLE_W){samp[SAMPLE_W-1]}}, samp} : sum_q;
		max_n       = take_max ? samp : max_q;
		max_off_n   = take_max ? off : max_off_q;
		first_off_n = (above && !seen_q) ? off : first_off_q;
		seen_n      = seen_q || above;
		cnt_n       = above ? cnt_q + OFF_W'(1) : cnt_q;
		has_n       = has_q || in_gate;
		fired_n     = has_n && (max_n > thresh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sum_q       <= '0;
			max_q       <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			max_off_q   <= '0;
			first_off_q <= '0;
			seen_q      <= 1'b0;
			cnt_q       <= '0;
			has_q       <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				idx_q       <= '0;
				sum_q       <= '0;
				max_q       <= {1'b1, {(SAMPLE_W-1){1'b0}}};
				max_off_q   <= '0;
				first_off_q <= '0;
				seen_q      <= 1'b0;
				cnt_q       <= '0;
				has_q       <= 1'b0;
			end else begin
				idx_q       <= (idx_q == IDX_MAX) ? idx_q : idx_q + IDX_W'(1);
				sum_q       <= sum_n;
				max_q       <= max_n;
				max_off_q   <= max_off_n;
				first_off_q <= first_off_n;
				seen_q      <= seen_n;
				cnt_q       <= cnt_n;
				has_q       <= has_n;
			end
		end
	end

	// snapshot on last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= acc && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && s_tlast) begin
			fired_s1     <= fired_n;
			seen_s1      <= seen_n;
			sum_s1       <= sum_n;
			max_s1       <= max_n;
			max_off_s1   <= max_off_n;
			first_off_s1 <= first_off_n;
			cnt_s1       <= cnt_n;
		end
	end

	// scale by sample period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			fired_s2 <= fired_s1;
			seen_s2  <= seen_s1;
			max_s2   <= max_s1;
			prod_s2  <= PROD_W'(sum_s1) * PROD_W'(signed'({1'b0, period_q}));
			tover_s2 <= TPROD_W'(cnt_s1) * TPROD_W'(period_q);
			arr_s2   <= TPROD_W'(first_off_s1) * TPROD_W'(period_q);
			ptime_s2 <= TPROD_W'(max_off_s1) * TPROD_W'(period_q);
		end
	end

	// truncate toward zero, saturate, select not-fired codes
	always_comb begin
		prod_bias = prod_s2[PROD_W-1] ? PROD_W'(prod_s2) + PROD_W'(255) : PROD_W'(prod_s2);
		scaled    = signed'(prod_bias[PROD_W-1:8]);
		if (&scaled[SCALED_W-1:CHARGE_W-1] || ~|scaled[SCALED_W-1:CHARGE_W-1]) begin
			charge_sat = scaled[CHARGE_W-1:0];
		end else if (scaled[SCALED_W-1]) begin
			charge_sat = {1'b1, {(CHARGE_W-1){1'b0}}};
		end else begin
			charge_sat = {1'b0, {(CHARGE_W-1){1'b1}}};
		end
		if (fired_s2) begin
			charge_n = charge_sat;
			peak_n   = max_s2;
			tover_n  = signed'({1'b0, tover_s2});
			arr_n    = seen_s2 ? signed'({1'b0, arr_s2}) : NO_TIME;
			ptime_n  = signed'({1'b0, ptime_s2});
		end else begin
			charge_n = '1;
			peak_n   = '1;
			tover_n  = NO_TIME;
			arr_n    = NO_TIME;
			ptime_n  = NO_TIME;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s2) begin
			fired_q <= fired_s2;
			out_q   <= {ptime_n, arr_n, tover_n, peak_n, charge_n};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = fired_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_q};

endmodule

`default_nettype wire

>>> verif/tb_gated_pulse_feature_extractor.sv
// ----------------------------------------------------------------------------
// Gated pulse feature extractor testbench
// Streams waveforms of signed samples into the extractor. Each gate setting
// is loaded while the block is idle. A predictor tracks the gate sum, the
// first maximum, threshold crossings and the scaled times of every waveform.
// Each result item is checked field by field against the oldest prediction,
// under random stalls on both streams except in the last third of the random phases.
// ----------------------------------------------------------------------------
module tb_gated_pulse_feature_extractor
	import gpfe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SETTLE_CYCLES = 8;
	localparam int unsigned LIMIT_CYCLES  = 400000;
	localparam int          RAND_PHASES   = 12;
	localparam int          PHASE_ITEMS   = 32;

	localparam logic [TIME_W-1:0] NO_TIME    = TIME_W'(-256);
	localparam longint            CHARGE_MAX = 64'sd2147483647;
	localparam longint            CHARGE_MIN = -64'sd2147483648;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} sample_item_t;

	typedef struct {
		logic                fired;
		logic [CHARGE_W-1:0] charge;
		logic [SAMPLE_W-1:0] peak_value;
		logic [TIME_W-1:0]   time_over;
		logic [TIME_W-1:0]   arrival_time;
		logic [TIME_W-1:0]   peak_time;
	} pulse_features_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic [SAMPLE_W-1:0]   s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tready  = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_ready;

	sample_item_t    pending_samples[$];
	pulse_features_t expected_features[$];

	int          send_idle_pct = 35;
	int          recv_idle_pct = 75;
	int          mismatches    = 0;
	int unsigned cycle_count   = 0;

	logic [GATE_START_W-1:0]    cfg_gate_start  = '0;
	logic [GATE_LEN_W-1:0]      cfg_gate_length = '0;
	logic signed [SAMPLE_W-1:0] cfg_threshold   = '0;
	logic [PERIOD_W-1:0]        cfg_period      = PERIOD_RST;

	logic [IDX_W-1:0]           wf_index;
	logic signed [SUM_W-1:0]    wf_sum;
	logic signed [SAMPLE_W-1:0] wf_max;
	logic [OFF_W-1:0]           wf_max_off;
	logic [OFF_W-1:0]           wf_first_off;
	logic                       wf_above_seen;
	logic [OFF_W-1:0]           wf_above_cnt;
	logic                       wf_gate_hit;

	gated_pulse_feature_extractor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic clear_waveform_state();
		wf_index      = '0;
		wf_sum        = '0;
		wf_max        = {1'b1, {(SAMPLE_W-1){1'b0}}};
		wf_max_off    = '0;
		wf_first_off  = '0;
		wf_above_seen = 1'b0;
		wf_above_cnt  = '0;
		wf_gate_hit   = 1'b0;
	endtask

	task automatic accumulate_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
		logic signed [SAMPLE_W-1:0] s;
		int                         idx;
		int                         gs;
		int                         len;
		int                         off;
		longint                     scaled;
		pulse_features_t            res;
		s   = raw;
		idx = wf_index;
		gs  = cfg_gate_start;
		len = (cfg_gate_length > MAX_GATE) ? MAX_GATE : cfg_gate_length;
		if (idx >= gs && idx - gs < len) begin
			off = idx - gs;
			wf_sum = wf_sum + s;
			if (!wf_gate_hit || s > wf_max) begin
				wf_max     = s;
				wf_max_off = OFF_W'(off);
			end
			if (s > cfg_threshold) begin
				if (!wf_above_seen) begin
					wf_above_seen = 1'b1;
					wf_first_off  = OFF_W'(off);
				end
				wf_above_cnt = wf_above_cnt + 1'b1;
			end
			wf_gate_hit = 1'b1;
		end
		if (wf_index != IDX_MAX)
			wf_index = wf_index + 1'b1;
		if (last) begin
			res.fired = wf_gate_hit && (wf_max > cfg_threshold);
			if (res.fired) begin
				scaled = (longint'(wf_sum) * longint'(cfg_period)) / 256;
				if (scaled > CHARGE_MAX)
					scaled = CHARGE_MAX;
				if (scaled < CHARGE_MIN)
					scaled = CHARGE_MIN;
				res.charge       = CHARGE_W'(scaled);
				res.peak_value   = wf_max;
				res.time_over    = TIME_W'(wf_above_cnt) * TIME_W'(cfg_period);
				res.arrival_time = wf_above_seen ?
					TIME_W'(wf_first_off) * TIME_W'(cfg_period) : NO_TIME;
				res.peak_time    = TIME_W'(wf_max_off) * TIME_W'(cfg_period);
			end else begin
				res.charge       = '1;
				res.peak_value   = '1;
				res.time_over    = NO_TIME;
				res.arrival_time = NO_TIME;
				res.peak_time    = NO_TIME;
			end
			expected_features.push_back(res);
			clear_waveform_state();
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : sample_driver
		sample_item_t next_item;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				accumulate_sample(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.value;
					s_tlast  <= next_item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		pulse_features_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_features.size() == 0) begin
					$error("result item with no waveform pending");
					mismatches++;
				end else begin
					want = expected_features.pop_front();
					check_field("fired", want.fired, m_tuser);
					check_field("charge", want.charge, m_tdata[31:0]);
					check_field("peak_value", want.peak_value, m_tdata[47:32]);
					check_field("time_over", want.time_over, m_tdata[75:48]);
					check_field("arrival_time", want.arrival_time, m_tdata[103:76]);
					check_field("peak_time", want.peak_time, m_tdata[131:104]);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic write_register(input cfg_reg_t reg_idx, input int value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'(value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (reg_idx)
			REG_GATE_START:    cfg_gate_start  = data[GATE_START_W-1:0];
			REG_GATE_LENGTH:   cfg_gate_length = data[GATE_LEN_W-1:0];
			REG_THRESHOLD:     cfg_threshold   = data;
			REG_SAMPLE_PERIOD: cfg_period      = data;
			default: ;
		endcase
	endtask

	task automatic configure(input int gs, input int gl, input int thr, input int per);
		write_register(REG_GATE_START, gs);
		write_register(REG_GATE_LENGTH, gl);
		write_register(REG_THRESHOLD, thr);
		write_register(REG_SAMPLE_PERIOD, per);
		@(negedge clk);
	endtask

	task automatic push_sample(input int value, input bit last);
		sample_item_t item;
		item.value = SAMPLE_W'(value);
		item.last  = last;
		pending_samples.push_back(item);
	endtask

	// hold until every item is taken and every result is back
	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid) @(negedge clk);
		while (expected_features.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_sample(input int mode, input int thr);
		int v;
		case (mode)
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = thr + int'($urandom_range(0, 128)) - 64;
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					default: v = -1;
				endcase
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	initial begin : stimulus
		int phase;
		int count;
		int wlen;
		int mode;
		int thr;
		int gs;
		int gl;
		int per;
		int k;
		int r;

		clear_waveform_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset gate is empty
		push_sample(10, 0);
		push_sample(-20, 0);
		push_sample(30, 1);
		drain();

		// tie on the maximum keeps the first offset
		configure(0, 4, 0, 256);
		push_sample(5, 0);
		push_sample(-3, 0);
		push_sample(7, 0);
		push_sample(7, 0);
		push_sample(2, 1);
		drain();

		// gate clipped at waveform end, sample extremes
		configure(2, 1024, -32768, 65535);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(-32768, 0);
		push_sample(32767, 0);
		push_sample(0, 1);
		drain();

		// waveform ends before the gate, oversized length
		configure(4095, 2047, 32767, 0);
		push_sample(100, 0);
		push_sample(-100, 1);
		drain();

		// zero period
		configure(0, 3, -1, 0);
		push_sample(0, 0);
		push_sample(-1, 0);
		push_sample(3, 1);
		drain();

		// gate non-empty but never above threshold
		configure(1, 2, 100, 1);
		push_sample(200, 0);
		push_sample(50, 0);
		push_sample(60, 0);
		push_sample(300, 1);
		drain();

		// negative charge truncates toward zero
		configure(0, 2, -10, 1);
		push_sample(-1, 0);
		push_sample(-2, 1);
		drain();

		configure(0, 1, -32768, 256);
		push_sample(-32767, 1);
		drain();

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == RAND_PHASES / 3) begin
				send_idle_pct = 75;
				recv_idle_pct = 35;

				// positive charge saturation
				configure(0, 1024, 0, 65535);
				for (k = 0; k < 260; k++)
					push_sample(32767, k == 259);
				drain();

				// negative charge saturation
				configure(0, 1024, -32768, 65535);
				for (k = 0; k < 260; k++)
					push_sample((k == 130) ? -32767 : -32768, k == 259);
				drain();
			end
			if (phase == 2 * RAND_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			gs = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(0, 4095);
			gs = gs | (int'($urandom_range(0, 15)) << GATE_START_W);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gl = $urandom_range(0, 16);
				6, 7:             gl = $urandom_range(17, 200);
				8:                gl = $urandom_range(1024, 2047);
				default:          gl = $urandom_range(0, 2047);
			endcase
			gl = gl | (int'($urandom_range(0, 31)) << GATE_LEN_W);
			if ($urandom_range(0, 1))
				thr = int'($urandom_range(0, 65535)) - 32768;
			else
				thr = int'($urandom_range(0, 600)) - 300;
			case ($urandom_range(0, 4))
				0:       per = 0;
				1:       per = 1;
				2:       per = 256;
				3:       per = 65535;
				default: per = $urandom_range(0, 65535);
			endcase
			configure(gs, gl, thr, per);

			count = 0;
			while (count < PHASE_ITEMS) begin
				r = $urandom_range(0, 19);
				if (r < 16)
					wlen = $urandom_range(1, 12);
				else if (r < 19)
					wlen = $urandom_range(13, 40);
				else
					wlen = $urandom_range(41, 120);
				mode = $urandom_range(0, 2);
				for (k = 0; k < wlen; k++)
					push_sample(pick_sample(mode, thr), k == wlen - 1);
				count += wlen;
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
